### hw/rtl/ddts_pkg.sv
// ----------------------------------------------------------------------------
// ddts_pkg: shared types and constants for the turn steering block
// Holds the CORDIC angle table, mode codes, sequencer states and the
// front/back queue entry.
// ----------------------------------------------------------------------------
package ddts_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam int CoordW      = 48;
    localparam int AngW        = 32;
    localparam int DivW        = 32;
    localparam int DivCntW     = $clog2(DivW + 1);

    localparam logic [2:0] CfgHard   = 3'd0;
    localparam logic [2:0] CfgSoft   = 3'd1;
    localparam logic [2:0] CfgNone   = 3'd2;
    localparam logic [2:0] CfgMaxSpd = 3'd3;

    typedef enum logic [1:0]
    {
        MODE_NONE = 2'd0,
        MODE_SOFT = 2'd1,
        MODE_HARD = 2'd2
    } mode_t;

    // Front sequencer states
    typedef enum logic [1:0]
    {
        F_IDLE,
        F_ITER,
        F_GAIN,
        F_OUT
    } fstate_t;

    // Back sequencer states
    typedef enum logic [1:0]
    {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_OUT
    } bstate_t;

    // Entry handed from front (CORDIC) to back (mode and speeds)
    typedef struct packed
    {
        logic signed [15:0] ang;
        logic [15:0]        len;
    } vec_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/ddts_front.sv
// ----------------------------------------------------------------------------
// ddts_front: heading vector to angle and length
// Iterative CORDIC in vectoring mode, one micro-rotation per cycle, then a
// gain multiply that yields the vector length.
// ----------------------------------------------------------------------------
module ddts_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  hx,
    input  logic signed [15:0]  hy,
    output logic                out_valid,
    input  logic                out_ready,
    output ddts_pkg::vec_t      out_vec
);

    ddts_pkg::fstate_t               state_reg, state_next;
    logic [ddts_pkg::StepW-1:0]      step_reg, step_next;
    logic signed [ddts_pkg::CoordW-1:0] x_reg, x_next, y_reg, y_next;
    logic [ddts_pkg::AngW-1:0]       z_reg, z_next;
    logic                            zero_reg, zero_next;
    ddts_pkg::vec_t                  vec_reg, vec_next;

    logic signed [ddts_pkg::CoordW-1:0] xs, ys, x0, y0, xc;
    logic [31:0]                     a16w;
    logic [64:0]                     prod;

    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign x0 = ddts_pkg::CoordW'(hx) <<< 8;
    assign y0 = ddts_pkg::CoordW'(hy) <<< 8;
    assign xc = x_reg[ddts_pkg::CoordW-1] ? '0 : x_reg;
    assign a16w = z_reg + 32'h8000;
    assign prod = 65'(unsigned'(xc)) * 65'd39797 + 65'(64'd1 << 23);

    assign in_ready  = (state_reg == ddts_pkg::F_IDLE);
    assign out_valid = (state_reg == ddts_pkg::F_OUT);
    assign out_vec   = vec_reg;

    // Hold state, vector and angle accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddts_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        vec_reg  <= vec_next;
    end

    // Advance the CORDIC sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        vec_next   = vec_reg;
        case (state_reg)
            ddts_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    zero_next = (hx == 16'sd0) && (hy == 16'sd0);
                    step_next = '0;
                    state_next = ddts_pkg::F_ITER;
                    if (hx < 0)
                    begin
                        if (hy >= 0)
                        begin
                            x_next = y0;
                            y_next = -x0;
                            z_next = 32'h40000000;
                        end
                        else
                        begin
                            x_next = -y0;
                            y_next = x0;
                            z_next = 32'hC0000000;
                        end
                    end
                    else
                    begin
                        x_next = x0;
                        y_next = y0;
                        z_next = '0;
                    end
                end
            end
            ddts_pkg::F_ITER:
            begin
                if (!y_reg[ddts_pkg::CoordW-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + ddts_pkg::atan_lut(5'(step_reg));
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - ddts_pkg::atan_lut(5'(step_reg));
                end
                step_next = step_reg + 1'b1;
                if (step_reg == ddts_pkg::StepW'(ddts_pkg::CordicSteps - 1))
                begin
                    state_next = ddts_pkg::F_GAIN;
                end
            end
            ddts_pkg::F_GAIN:
            begin
                if (zero_reg)
                begin
                    vec_next.ang = '0;
                    vec_next.len = '0;
                end
                else
                begin
                    vec_next.ang = a16w[31:16];
                    vec_next.len = prod[39:24];
                end
                state_next = ddts_pkg::F_OUT;
            end
            ddts_pkg::F_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ddts_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = ddts_pkg::F_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ddts_queue.sv
// ----------------------------------------------------------------------------
// ddts_queue: two-entry queue between front and back
// Lets the CORDIC start the next heading while the back end is busy.
// ----------------------------------------------------------------------------
module ddts_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ddts_pkg::vec_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ddts_pkg::vec_t  out_data
);

    ddts_pkg::vec_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

endmodule

### hw/rtl/ddts_back.sv
// ----------------------------------------------------------------------------
// ddts_back: turn mode and wheel speeds
// Hysteresis mode update, serial divide for the soft-turn factor,
// saturation and a result register.
// ----------------------------------------------------------------------------
module ddts_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ddts_pkg::vec_t      in_vec,
    input  logic [15:0]         hard_thr,
    input  logic [15:0]         soft_thr,
    input  logic [15:0]         none_thr,
    input  logic [14:0]         max_spd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  left_speed,
    output logic signed [15:0]  right_speed,
    output logic [1:0]          turn_mode,
    output logic                speed_saturated
);

    ddts_pkg::bstate_t               state_reg, state_next;
    ddts_pkg::mode_t                 mode_reg, mode_next;
    logic [15:0]                     base_reg, base_next;
    logic [15:0]                     num_reg, num_next;
    logic                            pos_reg, pos_next;
    logic [ddts_pkg::DivW-1:0]       dvd_reg, dvd_next, quo_reg, quo_next;
    logic [ddts_pkg::DivW:0]         rem_reg, rem_next;
    logic [ddts_pkg::DivCntW-1:0]    cnt_reg, cnt_next;
    logic signed [15:0]              left_reg, left_next, right_reg, right_next;
    logic                            sat_reg, sat_next;

    logic [15:0]                     absa, lenv;
    ddts_pkg::mode_t                 m0, m1, m2;
    logic [ddts_pkg::DivW:0]         rem_sh;
    logic signed [18:0]              s1, s2, lv, rv;

    assign in_ready        = (state_reg == ddts_pkg::B_IDLE);
    assign out_valid       = (state_reg == ddts_pkg::B_OUT);
    assign left_speed      = left_reg;
    assign right_speed     = right_reg;
    assign turn_mode       = mode_reg;
    assign speed_saturated = sat_reg;

    assign absa = in_vec.ang[15] ? 16'(-in_vec.ang) : in_vec.ang;
    assign lenv = in_vec.len;

    // Hysteresis update of the turn mode
    always_comb
    begin
        m0 = mode_reg;
        if (m0 == ddts_pkg::MODE_HARD && absa <= soft_thr)
        begin
            m0 = ddts_pkg::MODE_SOFT;
        end
        m1 = m0;
        if (m0 == ddts_pkg::MODE_SOFT)
        begin
            if (absa > hard_thr)
            begin
                m1 = ddts_pkg::MODE_HARD;
            end
            else if (absa <= none_thr)
            begin
                m1 = ddts_pkg::MODE_NONE;
            end
        end
        m2 = m1;
        if (m1 == ddts_pkg::MODE_NONE)
        begin
            if (absa > hard_thr)
            begin
                m2 = ddts_pkg::MODE_HARD;
            end
            else if (absa > none_thr)
            begin
                m2 = ddts_pkg::MODE_SOFT;
            end
        end
    end

    assign rem_sh = {rem_reg[ddts_pkg::DivW-1:0], dvd_reg[ddts_pkg::DivW-1]};

    // Pick inner and outer wheel speeds; they are saturated when latched below
    always_comb
    begin
        case (mode_reg)
            ddts_pkg::MODE_SOFT:
            begin
                s1 = 19'(quo_reg);
                s2 = 19'({base_reg, 1'b0}) - 19'(quo_reg);
            end
            ddts_pkg::MODE_HARD:
            begin
                s1 = -19'(max_spd);
                s2 = 19'(max_spd);
            end
            default:
            begin
                s1 = 19'(base_reg);
                s2 = 19'(base_reg);
            end
        endcase
        lv = pos_reg ? s1 : s2;
        rv = pos_reg ? s2 : s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddts_pkg::B_IDLE;
            mode_reg  <= ddts_pkg::MODE_NONE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        num_reg   <= num_next;
        pos_reg   <= pos_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        sat_reg   <= sat_next;
    end

    // Sequence: load, multiply, divide one bit a cycle in soft turn, present result
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        base_next  = base_reg;
        num_next   = num_reg;
        pos_next   = pos_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        right_next = right_reg;
        sat_next   = sat_reg;
        case (state_reg)
            ddts_pkg::B_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = m2;
                    base_next = (lenv < {1'b0, max_spd}) ? lenv : {1'b0, max_spd};
                    num_next  = hard_thr - absa;
                    pos_next  = !in_vec.ang[15] && (in_vec.ang != 16'sd0);
                    quo_next  = '0;
                    state_next = ddts_pkg::B_MUL;
                end
            end
            ddts_pkg::B_MUL:
            begin
                dvd_next = 32'(base_reg) * 32'(num_reg) + 32'(hard_thr[15:1]);
                rem_next = '0;
                cnt_next = '0;
                if (mode_reg == ddts_pkg::MODE_SOFT && hard_thr != 16'd0)
                begin
                    state_next = ddts_pkg::B_DIV;
                end
                else
                begin
                    quo_next = '0;
                    state_next = ddts_pkg::B_OUT;
                end
            end
            ddts_pkg::B_DIV:
            begin
                if (cnt_reg == ddts_pkg::DivCntW'(ddts_pkg::DivW))
                begin
                    state_next = ddts_pkg::B_OUT;
                end
                else
                begin
                    dvd_next = {dvd_reg[ddts_pkg::DivW-2:0], 1'b0};
                    if (rem_sh >= 33'(hard_thr))
                    begin
                        rem_next = rem_sh - 33'(hard_thr);
                        quo_next = {quo_reg[ddts_pkg::DivW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[ddts_pkg::DivW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ddts_pkg::B_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ddts_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ddts_pkg::B_IDLE;
            end
        endcase
        // Latch saturated speeds on entry to the output state
        if (state_next == ddts_pkg::B_OUT && state_reg != ddts_pkg::B_OUT)
        begin
            left_next  = (lv > 19'sd32767) ? 16'sh7FFF : 16'(lv);
            right_next = (rv > 19'sd32767) ? 16'sh7FFF : 16'(rv);
            sat_next   = (lv > 19'sd32767) || (rv > 19'sd32767);
        end
    end

endmodule

### hw/rtl/differential_drive_turn_steering.sv
// ----------------------------------------------------------------------------
// differential_drive_turn_steering: three-mode heading steering
// Soft turn takes longer than the other modes, since the 32-step serial
// divider runs only there. The CORDIC front and the back end each take a new
// heading only once done with the last; a two-entry queue between them lets the
// front go on while the back end is busy. Reset (rst_n, async low) clears turn
// mode to no turn and loads default thresholds.
// ----------------------------------------------------------------------------
module differential_drive_turn_steering
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // heading_x[15:0], heading_y[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // left, right, turn_mode, speed_saturated
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0]    hard_reg, soft_reg, none_reg;
    logic [14:0]    max_reg;
    logic           fv, fr, qv, qr;
    ddts_pkg::vec_t fvec, qvec;
    logic signed [15:0] ls, rs;
    logic [1:0]     tm;
    logic           sat;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_reg <= 16'd16384;
            soft_reg <= 16'd12743;
            none_reg <= 16'd1820;
            max_reg  <= 15'd2560;
        end
        else if (cfg_we)
        begin
            case ({1'b0, cfg_index})
                ddts_pkg::CfgHard:   hard_reg <= cfg_data;
                ddts_pkg::CfgSoft:   soft_reg <= cfg_data;
                ddts_pkg::CfgNone:   none_reg <= cfg_data;
                ddts_pkg::CfgMaxSpd: max_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    ddts_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .hx(s_axis_tdata[15:0]), .hy(s_axis_tdata[31:16]),
        .out_valid(fv), .out_ready(fr), .out_vec(fvec)
    );

    ddts_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fv), .in_ready(fr), .in_data(fvec),
        .out_valid(qv), .out_ready(qr), .out_data(qvec)
    );

    ddts_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(qv), .in_ready(qr), .in_vec(qvec),
        .hard_thr(hard_reg), .soft_thr(soft_reg),
        .none_thr(none_reg), .max_spd(max_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .left_speed(ls), .right_speed(rs),
        .turn_mode(tm), .speed_saturated(sat)
    );

    assign m_axis_tdata = {5'd0, sat, tm, rs, ls};

endmodule

### sim/differential_drive_turn_steering_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_turn_steering_tb: self-checking bench for turn steering
// Sends heading beats, predicts angle, length, turn mode and wheel speeds
// with a local CORDIC and hysteresis model, and checks every result beat.
// ----------------------------------------------------------------------------
module differential_drive_turn_steering_tb;

    localparam int DrainCycles = 80;
    localparam int StallLimit  = 5000;

    typedef struct
    {
        logic signed [15:0] left;
        logic signed [15:0] right;
        ddts_pkg::mode_t    mode;
        logic               sat;
    } wheel_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Local copy of the steering registers and turn state
    logic [15:0] hard_thr;
    logic [15:0] soft_thr;
    logic [15:0] none_thr;
    logic [14:0] speed_cap;
    ddts_pkg::mode_t steer_mode;

    wheel_cmd_t  pending_cmds[$];
    int          errors;
    int          headings_sent;
    int          cmds_checked;
    int          burst_left;
    int          stall_left;
    bit          rx_always_ready;
    int          quiet_cycles;

    differential_drive_turn_steering i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // heading_x[15:0], heading_y[31:16]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // left, right, turn_mode, speed_saturated
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Vector to angle (32768 = pi) and length
    task automatic heading_polar(input logic signed [15:0] hx, input logic signed [15:0] hy,
                                 output int ang, output longint len);
        longint      x;
        longint      y;
        longint      t;
        longint      nx;
        longint      ny;
        logic [31:0] z;
        logic [31:0] zr;
        begin
            ang = 0;
            len = 0;
            if (hx != 0 || hy != 0)
            begin
                x = longint'(hx) * 256;
                y = longint'(hy) * 256;
                z = 32'h0;
                // Pre-rotate the left half plane by a quarter turn
                if (x < 0)
                begin
                    t = x;
                    if (y >= 0)
                    begin
                        x = y;
                        y = -t;
                        z = 32'h40000000;
                    end
                    else
                    begin
                        x = -y;
                        y = t;
                        z = 32'hC0000000;
                    end
                end
                for (int i = 0; i < ddts_pkg::CordicSteps; i++)
                begin
                    if (y >= 0)
                    begin
                        nx = x + (y >>> i);
                        ny = y - (x >>> i);
                        z  = z + ddts_pkg::atan_lut(5'(i));
                    end
                    else
                    begin
                        nx = x - (y >>> i);
                        ny = y + (x >>> i);
                        z  = z - ddts_pkg::atan_lut(5'(i));
                    end
                    x = nx;
                    y = ny;
                end
                zr  = z + 32'h8000;
                ang = int'($signed(zr[31:16]));
                if (x < 0)
                    x = 0;
                len = (x * 39797 + (longint'(1) << 23)) >>> 24;
            end
        end
    endtask

    // Advance the turn state and work out the wheel command
    task automatic steer_heading(input logic signed [15:0] hx, input logic signed [15:0] hy,
                                 output wheel_cmd_t cmd);
        int     ang;
        int     absa;
        longint len;
        longint base;
        longint h;
        longint num;
        longint s1;
        longint s2;
        longint lw;
        longint rw;
        begin
            heading_polar(hx, hy, ang, len);
            absa = (ang < 0) ? -ang : ang;
            base = (len < longint'(speed_cap)) ? len : longint'(speed_cap);
            if (steer_mode == ddts_pkg::MODE_HARD && absa <= int'(soft_thr))
                steer_mode = ddts_pkg::MODE_SOFT;
            if (steer_mode == ddts_pkg::MODE_SOFT)
            begin
                if (absa > int'(hard_thr))
                    steer_mode = ddts_pkg::MODE_HARD;
                else if (absa <= int'(none_thr))
                    steer_mode = ddts_pkg::MODE_NONE;
            end
            if (steer_mode == ddts_pkg::MODE_NONE)
            begin
                if (absa > int'(hard_thr))
                    steer_mode = ddts_pkg::MODE_HARD;
                else if (absa > int'(none_thr))
                    steer_mode = ddts_pkg::MODE_SOFT;
            end
            if (steer_mode == ddts_pkg::MODE_SOFT)
            begin
                h   = longint'(hard_thr);
                num = h - absa;
                s1  = (h == 0 || num < 0) ? 0 : (base * num + h / 2) / h;
                s2  = 2 * base - s1;
            end
            else if (steer_mode == ddts_pkg::MODE_HARD)
            begin
                s1 = -longint'(speed_cap);
                s2 = longint'(speed_cap);
            end
            else
            begin
                s1 = base;
                s2 = base;
            end
            // Slow wheel goes left only for a strictly positive angle
            lw = (ang > 0) ? s1 : s2;
            rw = (ang > 0) ? s2 : s1;
            cmd.sat = 1'b0;
            if (lw > 32767)  begin lw = 32767;  cmd.sat = 1'b1; end
            if (lw < -32768) begin lw = -32768; cmd.sat = 1'b1; end
            if (rw > 32767)  begin rw = 32767;  cmd.sat = 1'b1; end
            if (rw < -32768) begin rw = -32768; cmd.sat = 1'b1; end
            cmd.left  = lw[15:0];
            cmd.right = rw[15:0];
            cmd.mode  = steer_mode;
        end
    endtask

    // Send one heading beat, with a random gap between bursts
    task automatic send_heading(input logic [15:0] hx, input logic [15:0] hy);
        wheel_cmd_t cmd;
        int         gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                if (gap > 0)
                begin
                    @(negedge clk);
                    s_axis_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            burst_left--;
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {hy, hx};
            do
                @(posedge clk);
            while (!s_axis_tready);
            steer_heading(hx, hy, cmd);
            pending_cmds.push_back(cmd);
            headings_sent++;
        end
    endtask

    // Drop valid, then wait until every result is back and the block is quiet
    task automatic drain;
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            wait (pending_cmds.size() == 0);
            repeat (DrainCycles) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(negedge clk);
            cfg_we    <= 1'b0;
            case (idx)
                ddts_pkg::CfgHard[1:0]:   hard_thr  = value;
                ddts_pkg::CfgSoft[1:0]:   soft_thr  = value;
                ddts_pkg::CfgNone[1:0]:   none_thr  = value;
                ddts_pkg::CfgMaxSpd[1:0]: speed_cap = value[14:0];
                default: ;
            endcase
        end
    endtask

    task automatic set_regs(input logic [15:0] h, input logic [15:0] s,
                            input logic [15:0] n, input logic [15:0] m);
        begin
            write_reg(ddts_pkg::CfgHard[1:0], h);
            write_reg(ddts_pkg::CfgSoft[1:0], s);
            write_reg(ddts_pkg::CfgNone[1:0], n);
            write_reg(ddts_pkg::CfgMaxSpd[1:0], m);
        end
    endtask

    // Random heading: full range, short vectors, or near an axis
    task automatic send_random_heading;
        logic [15:0] hx;
        logic [15:0] hy;
        int          r;
        begin
            r  = $urandom_range(0, 3);
            hx = 16'($urandom);
            hy = 16'($urandom);
            if (r == 1)
            begin
                hx = 16'($urandom_range(0, 4000) - 2000);
                hy = 16'($urandom_range(0, 4000) - 2000);
            end
            else if (r == 2)
            begin
                hy = 16'($urandom_range(0, 600) - 300);
                if ($urandom_range(0, 1) == 1)
                    {hx, hy} = {hy, hx};
            end
            send_heading(hx, hy);
        end
    endtask

    task automatic test_directed;
        begin
            send_heading(16'h0000, 16'h0000);   // zero vector
            send_heading(16'h7FFF, 16'h0000);
            send_heading(16'h8000, 16'h0000);   // angle of pi
            send_heading(16'hFFFF, 16'h0000);
            send_heading(16'h0000, 16'h7FFF);
            send_heading(16'h0000, 16'h8000);
            send_heading(16'h8000, 16'h8000);
            send_heading(16'h7FFF, 16'h7FFF);
            send_heading(16'h7FFF, 16'h8000);
            send_heading(16'h8000, 16'h7FFF);
            send_heading(16'h0100, 16'h0030);   // small angle, soft
            send_heading(16'h0100, 16'h0003);   // back to straight
            send_heading(16'h0100, 16'h0100);   // soft, left slow
            send_heading(16'h0100, 16'hFF00);   // soft, right slow
            send_heading(16'h0000, 16'h0200);   // quarter turn, stays soft
            send_heading(16'h0100, 16'h00C0);   // below the soft threshold, stays soft
            send_heading(16'h0100, 16'h0040);   // above the no-turn threshold, stays soft
            send_heading(16'h5555, 16'hAAAA);
            send_heading(16'hAAAA, 16'h5555);
            send_heading(16'h0001, 16'h0001);
            drain();
        end
    endtask

    // Extreme settings, each with a short random run
    task automatic test_register_extremes;
        begin
            set_regs(16'd0, 16'd0, 16'd0, 16'h7FFF);        // zero factor, max clamp
            repeat (40) send_random_heading();
            drain();
            set_regs(16'd32768, 16'd32768, 16'd32768, 16'd0);
            repeat (30) send_random_heading();
            drain();
            set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF); // beyond pi, unsigned
            repeat (30) send_random_heading();
            drain();
            set_regs(16'd8000, 16'd30000, 16'd500, 16'h7FFF); // outer wheel saturates
            repeat (40) send_random_heading();
            drain();
        end
    endtask

    task automatic test_random;
        logic [15:0] h;
        begin
            for (int phase = 0; phase < 8; phase++)
            begin
                rx_always_ready = (phase == 3);
                h = 16'($urandom_range(0, 32768));
                set_regs(h, 16'($urandom_range(0, h)), 16'($urandom_range(0, h / 2 + 1)),
                         $urandom_range(0, 1) ? 16'($urandom_range(0, 32767))
                                              : 16'($urandom_range(0, 4000)));
                repeat (60) send_random_heading();
                drain();
            end
            rx_always_ready = 1'b0;
            set_regs(16'd16384, 16'd12743, 16'd1820, 16'd2560);
            repeat (40) send_random_heading();
            drain();
        end
    endtask

    // Receiver stall pattern: random stall runs, and phases with none
    always @(negedge clk)
    begin
        if (rx_always_ready)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        wheel_cmd_t exp_cmd;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_cmd = pending_cmds.pop_front();
                cmds_checked++;
                if (m_axis_tdata[15:0] !== exp_cmd.left)
                begin
                    $display("%0t: left_speed expected %0d actual %0d", $time,
                             exp_cmd.left, $signed(m_axis_tdata[15:0]));
                    errors++;
                end
                if (m_axis_tdata[31:16] !== exp_cmd.right)
                begin
                    $display("%0t: right_speed expected %0d actual %0d", $time,
                             exp_cmd.right, $signed(m_axis_tdata[31:16]));
                    errors++;
                end
                if (m_axis_tdata[33:32] !== exp_cmd.mode)
                begin
                    $display("%0t: turn_mode expected %0d actual %0d", $time,
                             exp_cmd.mode, m_axis_tdata[33:32]);
                    errors++;
                end
                if (m_axis_tdata[34] !== exp_cmd.sat)
                begin
                    $display("%0t: speed_saturated expected %0b actual %0b", $time,
                             exp_cmd.sat, m_axis_tdata[34]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
            $display("differential_drive_turn_steering: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        errors          = 0;
        headings_sent   = 0;
        cmds_checked    = 0;
        burst_left      = 0;
        stall_left      = 0;
        rx_always_ready = 1'b0;
        quiet_cycles    = 0;
        hard_thr        = 16'd16384;
        soft_thr        = 16'd12743;
        none_thr        = 16'd1820;
        speed_cap       = 15'd2560;
        steer_mode      = ddts_pkg::MODE_NONE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_extremes();
        test_random();

        $display("Sent %0d headings and checked %0d wheel commands over", headings_sent,
                 cmds_checked);
        $display("default, extreme and random thresholds and speed caps.");
        if (errors == 0)
            $display("differential_drive_turn_steering: match");
        else
            $display("differential_drive_turn_steering: mismatch");
        $finish;
    end

endmodule
